// ===== src/e2c_pkg.sv =====
// Shared constants and calendar helper functions for the epoch to calendar converter.
package e2c_pkg;

  localparam int unsigned EpochBits   = 32;
  localparam int unsigned DayBits     = 16;
  localparam int unsigned SodBits     = 17;
  localparam int unsigned YearBits    = 12;
  localparam int unsigned YdayBits    = 9;
  localparam int unsigned MonthBits   = 4;
  localparam int unsigned MdayBits    = 5;
  localparam int unsigned HourBits    = 5;
  localparam int unsigned MinBits     = 6;
  localparam int unsigned SecBits     = 6;
  localparam int unsigned WdayBits    = 3;
  localparam int unsigned CycleBits   = 6;
  localparam int unsigned CycRemBits  = 11;
  localparam int unsigned HourRemBits = 12;

  // Seconds per day factors as 2^7 * 675, so the low seven bits bypass the divider.
  localparam int unsigned DayShift    = 7;
  localparam int unsigned DayOddPart  = 675;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerCyc  = 1461;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned DaysTo1973  = 1096;
  localparam int unsigned BaseYear    = 1973;
  localparam logic [EpochBits-1:0] Start1973Secs = EpochBits'(DaysTo1973 * 86400);

  // First day of year of each month, with the leap day folded in from March on.
  function automatic logic [YdayBits-1:0] month_start(input logic [MonthBits-1:0] m,
                                                     input logic leap);
    logic [YdayBits-1:0] s;
    begin
      case (m)
        4'd0:    s = 9'd0;
        4'd1:    s = 9'd31;
        4'd2:    s = 9'd59;
        4'd3:    s = 9'd90;
        4'd4:    s = 9'd120;
        4'd5:    s = 9'd151;
        4'd6:    s = 9'd181;
        4'd7:    s = 9'd212;
        4'd8:    s = 9'd243;
        4'd9:    s = 9'd273;
        4'd10:   s = 9'd304;
        4'd11:   s = 9'd334;
        default: s = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
        s = s + 9'd1;
      end
      return s;
    end
  endfunction

  // Day 0 of the epoch was a Thursday. Since 8 is 1 modulo 7, the octal digits
  // of the day count are summed and the small sum is folded twice.
  function automatic logic [WdayBits-1:0] weekday_of(input logic [DayBits-1:0] days);
    logic [5:0] sum;
    logic [3:0] fold;
    begin
      sum = 6'(days[2:0]) + 6'(days[5:3]) + 6'(days[8:6]) + 6'(days[11:9])
          + 6'(days[14:12]) + 6'(days[15]) + 6'd4;
      fold = 4'(sum[5:3]) + 4'(sum[2:0]);
      if (fold >= 4'd7) begin
        fold = fold - 4'd7;
      end
      if (fold >= 4'd7) begin
        fold = fold - 4'd7;
      end
      return fold[WdayBits-1:0];
    end
  endfunction

endpackage

// ===== src/e2c_const_div.sv =====
// Three-stage pipelined division of an unsigned value by a constant.
module e2c_const_div #(
  parameter int unsigned XW      = 16,
  parameter int unsigned QW      = 8,
  parameter int unsigned Divisor = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [XW-1:0]                dividend_i,
  output logic                         valid_o,
  output logic [QW-1:0]                quot_o,
  output logic [$clog2(Divisor)-1:0]   rem_o
);

  localparam int unsigned RW = $clog2(Divisor);
  localparam int unsigned MW = XW - RW + 1;
  // Truncated reciprocal: the estimate is the true quotient or one below it.
  localparam logic [MW-1:0] Recip = MW'((64'd1 << XW) / Divisor);
  localparam int unsigned PW = XW + MW;

  logic          v1_q, v2_q, v3_q;
  logic [PW-1:0] prod_q;
  logic [XW-1:0] x_q;
  logic [QW-1:0] q0_q, q0_d;
  logic [RW:0]   r0_q, r0_d;
  logic [QW-1:0] quot_q;
  logic [RW-1:0] rem_q;
  logic [XW-1:0] back;

  always_comb begin
    q0_d = prod_q[XW +: QW];
    back = XW'(q0_d * Divisor);
    r0_d = (RW + 1)'(x_q - back);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(dividend_i) * PW'(Recip);
    x_q    <= dividend_i;
    q0_q   <= q0_d;
    r0_q   <= r0_d;
    if (r0_q >= (RW + 1)'(Divisor)) begin
      quot_q <= q0_q + QW'(1);
      rem_q  <= RW'(r0_q - (RW + 1)'(Divisor));
    end else begin
      quot_q <= q0_q;
      rem_q  <= RW'(r0_q);
    end
  end

  assign valid_o = v3_q;
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;

endmodule

// ===== src/epoch_to_calendar.sv =====
// Top level of the pipelined epoch seconds to calendar date and time converter.
//
// Usage: drive epoch_seconds_i and raise start_i; the beat is taken at any rising
// edge where start_i is high and busy_o is low. busy_o is always low, because the
// pipeline takes a new epoch in every cycle, one conversion per clock sustained.
// For each result beat, done_o is high for exactly one cycle and the calendar
// fields are valid in that cycle. Results leave in the order the epochs arrived.
// The receiver has no way to hold results back, so the pipeline never stalls and
// no beat is ever dropped.
// The pipeline is a chain of constant dividers, three stages each: day count,
// then four-year cycle and hour in parallel, then minute and second.
// Epochs before the first of January 1973 give valid_res_o low and all other
// fields zero. Leap years follow the plain every-fourth-year rule, so dates are
// exact through 2099. Reset clears the valid bits of every stage; any beats in
// flight are discarded and no done_o pulse follows until new beats arrive.
module epoch_to_calendar (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [e2c_pkg::EpochBits-1:0]      epoch_seconds_i,
  output logic                               done_o,
  output logic                               valid_res_o,
  output logic [e2c_pkg::YearBits-1:0]       year_o,
  output logic [e2c_pkg::MonthBits-1:0]      month_o,
  output logic [e2c_pkg::MdayBits-1:0]       day_of_month_o,
  output logic [e2c_pkg::YdayBits-1:0]       day_of_year_o,
  output logic [e2c_pkg::HourBits-1:0]       hour_o,
  output logic [e2c_pkg::MinBits-1:0]        minute_o,
  output logic [e2c_pkg::SecBits-1:0]        second_o,
  output logic [e2c_pkg::WdayBits-1:0]       weekday_o
);

  localparam int unsigned DlyA = 3;
  localparam int unsigned DlyB = 3;
  localparam int unsigned HiBits = e2c_pkg::EpochBits - e2c_pkg::DayShift;
  localparam int unsigned DayRemBits = $clog2(e2c_pkg::DayOddPart);

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage group A: day count and second of day. The epoch is split into its
  // high bits, which are divided by 675, and the low seven bits, which are the
  // low bits of the second of day unchanged.
  // ---------------------------------------------------------------------------
  logic                          a_vld;
  logic [e2c_pkg::DayBits-1:0]   a_days;
  logic [DayRemBits-1:0]         a_rem;
  logic [e2c_pkg::DayShift-1:0]  lo_q  [DlyA];
  logic                          inr_q [DlyA];

  e2c_const_div #(
    .XW      (HiBits),
    .QW      (e2c_pkg::DayBits),
    .Divisor (e2c_pkg::DayOddPart)
  ) u_div_day (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .dividend_i (epoch_seconds_i[e2c_pkg::EpochBits-1:e2c_pkg::DayShift]),
    .valid_o    (a_vld),
    .quot_o     (a_days),
    .rem_o      (a_rem)
  );

  always_ff @(posedge clk_i) begin
    lo_q[0]  <= epoch_seconds_i[e2c_pkg::DayShift-1:0];
    inr_q[0] <= (epoch_seconds_i >= e2c_pkg::Start1973Secs);
    for (int i = 1; i < DlyA; i++) begin
      lo_q[i]  <= lo_q[i-1];
      inr_q[i] <= inr_q[i-1];
    end
  end

  logic [e2c_pkg::SodBits-1:0]  a_sod;
  logic [e2c_pkg::DayBits-1:0]  a_dd;
  logic [e2c_pkg::WdayBits-1:0] a_wday;

  always_comb begin
    a_sod  = {a_rem, lo_q[DlyA-1]};
    // Days since 1973; the value is meaningless for early epochs, which are
    // zeroed at the output anyway.
    a_dd   = a_days - e2c_pkg::DayBits'(e2c_pkg::DaysTo1973);
    a_wday = e2c_pkg::weekday_of(a_days);
  end

  // ---------------------------------------------------------------------------
  // Stage group B: four-year cycle and day within the cycle, in parallel with
  // the hour and second within the hour.
  // ---------------------------------------------------------------------------
  localparam int unsigned CycRemBits_w = e2c_pkg::CycRemBits;

  logic                             b_vld;
  logic [e2c_pkg::CycleBits-1:0]    b_cyc;
  logic [CycRemBits_w-1:0]          b_crem;
  logic                             c_vld;
  logic [e2c_pkg::HourBits-1:0]     c_hour;
  logic [e2c_pkg::HourRemBits-1:0]  c_hrem;
  logic                             inr2_q [DlyB];
  logic [e2c_pkg::WdayBits-1:0]     wd2_q  [DlyB];

  e2c_const_div #(
    .XW      (e2c_pkg::DayBits),
    .QW      (e2c_pkg::CycleBits),
    .Divisor (e2c_pkg::DaysPerCyc)
  ) u_div_cycle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (a_vld),
    .dividend_i (a_dd),
    .valid_o    (b_vld),
    .quot_o     (b_cyc),
    .rem_o      (b_crem)
  );

  e2c_const_div #(
    .XW      (e2c_pkg::SodBits),
    .QW      (e2c_pkg::HourBits),
    .Divisor (e2c_pkg::SecsPerHour)
  ) u_div_hour (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (a_vld),
    .dividend_i (a_sod),
    .valid_o    (c_vld),
    .quot_o     (c_hour),
    .rem_o      (c_hrem)
  );

  always_ff @(posedge clk_i) begin
    inr2_q[0] <= inr_q[DlyA-1];
    wd2_q[0]  <= a_wday;
    for (int i = 1; i < DlyB; i++) begin
      inr2_q[i] <= inr2_q[i-1];
      wd2_q[i]  <= wd2_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage group D: minute and second, divided from the second within the hour.
  // ---------------------------------------------------------------------------
  logic                           d_vld;
  logic [e2c_pkg::MinBits-1:0]    d_min;
  logic [e2c_pkg::SecBits-1:0]    d_sec;

  // Both dividers of stage group B run in lockstep, so their valid bits agree.
  e2c_const_div #(
    .XW      (e2c_pkg::HourRemBits),
    .QW      (e2c_pkg::MinBits),
    .Divisor (e2c_pkg::SecsPerMin)
  ) u_div_min (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_vld && c_vld),
    .dividend_i (c_hrem),
    .valid_o    (d_vld),
    .quot_o     (d_min),
    .rem_o      (d_sec)
  );

  // ---------------------------------------------------------------------------
  // Date path, running beside the minute divider. The first register finds the
  // year within the cycle; the fourth year is the leap year and also owns the
  // last day of the cycle. The second register finds month and day of month.
  // The third register only keeps the date aligned with the minute divider.
  // ---------------------------------------------------------------------------
  logic [1:0]                      ry;
  logic [e2c_pkg::YdayBits-1:0]    yday_d;
  logic [e2c_pkg::YearBits-1:0]    year_d;
  logic                            leap_d;
  logic [CycRemBits_w-1:0]         cut;

  always_comb begin
    ry = 2'd0;
    if (b_crem >= CycRemBits_w'(e2c_pkg::DaysPerYear)) begin
      ry = 2'd1;
    end
    if (b_crem >= CycRemBits_w'(2 * e2c_pkg::DaysPerYear)) begin
      ry = 2'd2;
    end
    if (b_crem >= CycRemBits_w'(3 * e2c_pkg::DaysPerYear)) begin
      ry = 2'd3;
    end
    leap_d = (ry == 2'd3);
    case (ry)
      2'd0:    cut = '0;
      2'd1:    cut = CycRemBits_w'(e2c_pkg::DaysPerYear);
      2'd2:    cut = CycRemBits_w'(2 * e2c_pkg::DaysPerYear);
      2'd3:    cut = CycRemBits_w'(3 * e2c_pkg::DaysPerYear);
      default: cut = '0;
    endcase
    yday_d = e2c_pkg::YdayBits'(b_crem - cut);
    year_d = e2c_pkg::YearBits'(e2c_pkg::BaseYear) + e2c_pkg::YearBits'({b_cyc, 2'b00})
           + e2c_pkg::YearBits'(ry);
  end

  logic [e2c_pkg::YearBits-1:0]   e1_year_q, e2_year_q, e3_year_q;
  logic [e2c_pkg::YdayBits-1:0]   e1_yday_q, e2_yday_q, e3_yday_q;
  logic                           e1_leap_q;
  logic [e2c_pkg::HourBits-1:0]   e1_hour_q, e2_hour_q, e3_hour_q;
  logic [e2c_pkg::MonthBits-1:0]  e2_mon_q, e3_mon_q;
  logic [e2c_pkg::MdayBits-1:0]   e2_mday_q, e3_mday_q;
  logic [e2c_pkg::MonthBits-1:0]  mon_d;
  logic [e2c_pkg::MdayBits-1:0]   mday_d;

  // Month is the last one whose first day is not after the day of year; the
  // eleven compares are independent of each other.
  always_comb begin
    mon_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (e1_yday_q >= e2c_pkg::month_start(e2c_pkg::MonthBits'(k), e1_leap_q)) begin
        mon_d = e2c_pkg::MonthBits'(k);
      end
    end
    mday_d = e2c_pkg::MdayBits'(e1_yday_q - e2c_pkg::month_start(mon_d, e1_leap_q) + 9'd1);
  end

  always_ff @(posedge clk_i) begin
    e1_year_q <= year_d;
    e1_yday_q <= yday_d;
    e1_leap_q <= leap_d;
    e1_hour_q <= c_hour;

    e2_year_q <= e1_year_q;
    e2_yday_q <= e1_yday_q;
    e2_hour_q <= e1_hour_q;
    e2_mon_q  <= mon_d;
    e2_mday_q <= mday_d;

    e3_year_q <= e2_year_q;
    e3_yday_q <= e2_yday_q;
    e3_hour_q <= e2_hour_q;
    e3_mon_q  <= e2_mon_q;
    e3_mday_q <= e2_mday_q;
  end

  logic                           inr3_q [DlyB];
  logic [e2c_pkg::WdayBits-1:0]   wd3_q  [DlyB];

  always_ff @(posedge clk_i) begin
    inr3_q[0] <= inr2_q[DlyB-1];
    wd3_q[0]  <= wd2_q[DlyB-1];
    for (int i = 1; i < DlyB; i++) begin
      inr3_q[i] <= inr3_q[i-1];
      wd3_q[i]  <= wd3_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Early epochs are forced to all zeros here.
  // ---------------------------------------------------------------------------
  logic                           done_q;
  logic                           ok;
  logic                           vres_q;
  logic [e2c_pkg::YearBits-1:0]   year_q;
  logic [e2c_pkg::MonthBits-1:0]  mon_q;
  logic [e2c_pkg::MdayBits-1:0]   mday_q;
  logic [e2c_pkg::YdayBits-1:0]   yday_q;
  logic [e2c_pkg::HourBits-1:0]   hour_q;
  logic [e2c_pkg::MinBits-1:0]    min_q;
  logic [e2c_pkg::SecBits-1:0]    sec_q;
  logic [e2c_pkg::WdayBits-1:0]   wday_q;

  assign ok = inr3_q[DlyB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    vres_q <= ok;
    year_q <= ok ? e3_year_q : '0;
    mon_q  <= ok ? e3_mon_q  : '0;
    mday_q <= ok ? e3_mday_q : '0;
    yday_q <= ok ? e3_yday_q : '0;
    hour_q <= ok ? e3_hour_q : '0;
    min_q  <= ok ? d_min     : '0;
    sec_q  <= ok ? d_sec     : '0;
    wday_q <= ok ? wd3_q[DlyB-1] : '0;
  end

  assign done_o         = done_q;
  assign valid_res_o    = vres_q;
  assign year_o         = year_q;
  assign month_o        = mon_q;
  assign day_of_month_o = mday_q;
  assign day_of_year_o  = yday_q;
  assign hour_o         = hour_q;
  assign minute_o       = min_q;
  assign second_o       = sec_q;
  assign weekday_o      = wday_q;

endmodule
